[sv/fts_pkg.sv]
package fts_pkg;

   // input frame geometry
   localparam int IN_FRAME_BYTES = 16;
   localparam int POS_WIDTH      = $clog2(IN_FRAME_BYTES);
   localparam int STAMP_BYTES    = 4;
   localparam int IDX_WIDTH      = $clog2(STAMP_BYTES + 1);

   // crc constants
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY_RESET = 16'hA001;

   // register file
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic REG_CRC_POLYNOMIAL = 1'b0;

   // item kinds decided when a byte is taken in
   localparam logic [2:0] KIND_FIRST  = 3'd0;
   localparam logic [2:0] KIND_PASS   = 3'd1;
   localparam logic [2:0] KIND_CRC    = 3'd2;
   localparam logic [2:0] KIND_DROP   = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] time_stamp;
      logic        checksum_ok;
   } item_type;

   // one byte through the reflected crc, bit at a time
   function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                            input logic [7:0]  data,
                                            input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ poly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/fts_req_if.sv]
interface fts_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [31:0] time_stamp;
   logic        is_checksum_byte;

   modport source (output valid, output data_byte, output time_stamp,
                   output is_checksum_byte, input ready);
   modport sink   (input valid, input data_byte, input time_stamp,
                   input is_checksum_byte, output ready);
endinterface

[sv/fts_rsp_if.sv]
interface fts_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_status;
   logic       checksum_ok;
   logic       last_of_run;

   modport source (output valid, output out_byte, output is_status,
                   output checksum_ok, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input is_status,
                   input checksum_ok, input last_of_run, output ready);
endinterface

[sv/fts_frontend.sv]
module fts_frontend
   import fts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   fts_req_if.sink  req_chan,
   input  logic     item_done,
   output logic     item_valid,
   output item_type item
);

   logic                 valid_ff, valid_in;
   item_type             item_ff, item_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]           sum_ff, sum_in;
   logic                 accept;

   // free slot, or the held item leaves this cycle
   assign req_chan.ready = !valid_ff || item_done;
   assign accept         = req_chan.valid && req_chan.ready;
   assign item_valid     = valid_ff;
   assign item           = item_ff;

   // classify the byte by frame position, keep the batch sum
   always_comb begin
      pos_in                = pos_ff;
      sum_in                = sum_ff;
      item_in               = item_ff;
      item_in.data_byte     = req_chan.data_byte;
      item_in.time_stamp    = req_chan.time_stamp;
      item_in.checksum_ok   = (sum_ff == req_chan.data_byte);
      if (req_chan.is_checksum_byte) begin
         item_in.kind = KIND_STATUS;
         pos_in       = '0;
         sum_in       = '0;
      end else begin
         sum_in = sum_ff + req_chan.data_byte;
         if (pos_ff == '0) begin
            item_in.kind = KIND_FIRST;
         end else if (pos_ff < POS_WIDTH'(IN_FRAME_BYTES - 2)) begin
            item_in.kind = KIND_PASS;
         end else if (pos_ff == POS_WIDTH'(IN_FRAME_BYTES - 2)) begin
            item_in.kind = KIND_CRC;
         end else begin
            item_in.kind = KIND_DROP;
         end
         if (pos_ff == POS_WIDTH'(IN_FRAME_BYTES - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
      if (!accept) begin
         item_in = item_ff;
         pos_in  = pos_ff;
         sum_in  = sum_ff;
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_done) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= '0;
         sum_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

[sv/fts_emitter.sv]
module fts_emitter
   import fts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   input  logic [15:0] crc_polynomial,
   output logic        item_done,
   fts_rsp_if.source   rsp_chan
);

   logic [IDX_WIDTH-1:0] idx_ff, idx_in;
   logic [15:0]          crc_ff, crc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           out_byte_ff;
   logic                 is_status_ff, checksum_ok_ff, last_ff;

   logic        out_free, has_output, last, feed, clear, step;
   logic [7:0]  emit_byte;
   logic [15:0] feed_base;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // pick the byte for this step of the item
   always_comb begin
      emit_byte  = 8'h00;
      last       = 1'b1;
      feed       = 1'b0;
      clear      = 1'b0;
      has_output = 1'b1;
      feed_base  = crc_ff;
      case (item.kind)
         KIND_FIRST: begin
            feed = 1'b1;
            last = (idx_ff == IDX_WIDTH'(STAMP_BYTES));
            if (idx_ff == '0) begin
               feed_base = CRC_INIT;
            end
            case (idx_ff)
               IDX_WIDTH'(0): emit_byte = item.time_stamp[31:24];
               IDX_WIDTH'(1): emit_byte = item.time_stamp[23:16];
               IDX_WIDTH'(2): emit_byte = item.time_stamp[15:8];
               IDX_WIDTH'(3): emit_byte = item.time_stamp[7:0];
               default:       emit_byte = item.data_byte;
            endcase
         end
         KIND_PASS: begin
            feed      = 1'b1;
            emit_byte = item.data_byte;
         end
         KIND_CRC: begin
            last      = (idx_ff != '0);
            emit_byte = (idx_ff == '0) ? crc_ff[15:8] : crc_ff[7:0];
         end
         KIND_STATUS: begin
            clear = 1'b1;
         end
         default: begin
            has_output = 1'b0;
         end
      endcase
   end

   assign step      = item_valid && out_free && has_output;
   assign item_done = item_valid && (!has_output || (out_free && last));

   // crc, step counter and output register
   always_comb begin
      crc_in = crc_ff;
      idx_in = idx_ff;
      if (step) begin
         if (feed) begin
            crc_in = crc_feed(feed_base, emit_byte, crc_polynomial);
         end else if (clear) begin
            crc_in = CRC_INIT;
         end
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_byte_ff    <= emit_byte;
         is_status_ff   <= clear;
         checksum_ok_ff <= clear && item.checksum_ok;
         last_ff        <= last;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.is_status   = is_status_ff;
   assign rsp_chan.checksum_ok = checksum_ok_ff;
   assign rsp_chan.last_of_run = last_ff;

endmodule

[sv/frame_timestamp_crc_restamper_unit.sv]
// channel    dir  payload                                        handshake
// req_chan   in   data_byte, time_stamp, is_checksum_byte        valid/ready
// rsp_chan   out  out_byte, is_status, checksum_ok, last_of_run  valid/ready
// csr_*      in   crc_polynomial at byte address 0               apb, pready high
//
// one output byte per cycle from the output register; the emitter walks an item
// one byte a cycle: frame byte 0 gives four stamp bytes then its data byte, bytes
// 1 to 13 their byte, byte 14 two crc bytes, byte 15 none, a checksum byte a status;
// the crc steps one byte per stamp or data byte alongside the output register
// synchronous reset clears position, sum and valid flags, inits crc; no clearing pass
// a stalled output holds its byte; the next byte is taken as the held item finishes
module frame_timestamp_crc_restamper_unit
   import fts_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   fts_req_if.sink                   req_chan,
   fts_rsp_if.source                 rsp_chan,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic        poly_sel, poly_we;
   logic [15:0] crc_polynomial_ff, crc_polynomial_in;
   logic        item_valid, item_done;
   item_type    item;

   // register file
   assign csr_pready = 1'b1;
   assign poly_we    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_WIDTH-1] == REG_CRC_POLYNOMIAL);
   assign crc_polynomial_in = poly_we ? csr_pwdata[15:0] : crc_polynomial_ff;
   assign poly_sel   = (csr_paddr[CSR_ADDR_WIDTH-1] == REG_CRC_POLYNOMIAL);
   assign csr_prdata = poly_sel ? {{(CSR_DATA_WIDTH - 16){1'b0}}, crc_polynomial_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_polynomial_ff <= CRC_POLY_RESET;
      end else begin
         crc_polynomial_ff <= crc_polynomial_in;
      end
   end

   fts_frontend u_frontend (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .item_done  (item_done),
      .item_valid (item_valid),
      .item       (item)
   );

   fts_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .crc_polynomial (crc_polynomial_ff),
      .item_done      (item_done),
      .rsp_chan       (rsp_chan)
   );

   // status results are single and carry no byte
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.is_status |-> rsp_chan.last_of_run
                                              && (rsp_chan.out_byte == 8'h00))
      else $error("status transfer malformed");

   // verdict bit only in status results
   a_ok_only_status: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.is_status |-> !rsp_chan.checksum_ok)
      else $error("checksum_ok set on a byte transfer");

   // an empty item slot always takes input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !item_valid |-> req_chan.ready)
      else $error("input stalled with no item held");

   // an unfinished item holds until done
   a_item_holds: assert property (@(posedge clock) disable iff (reset)
      item_valid && !item_done |=> item_valid && $stable(item))
      else $error("held item changed before it finished");

endmodule
